FILE: src/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: channel payloads,
// operation and status codes, and the command passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int QDEPTH    = 2;

    // operation codes on the input channel
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_FRONT  = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_DUMP   = 3'd4;

    // status codes on the result channel
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_ELEMENT = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         position_in;
        logic signed [31:0] value_in;
    } ils_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] element;
        logic [3:0]         element_position;
        logic               last;
        logic [4:0]         count_out;
    } ils_out_t;

    typedef enum logic [2:0] {
        CMD_APPEND,
        CMD_FRONT,
        CMD_INSERT,
        CMD_DELETE,
        CMD_DUMP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         pos;
        logic signed [31:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        BK_IDLE,
        BK_DUMP
    } back_state_t;

endpackage

`default_nettype wire

FILE: src/ils_front.sv
// ----------------------------------------------------------------------------
// ils_front
// Accepts input transactions, decodes the operation and queues the command
// for the back end. Unused operation codes are accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_front
    import ils_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire ils_in_t s_data,
    output logic         cmd_valid,
    input  wire logic    cmd_ready,
    output cmd_t         cmd
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    cmd_t           q_mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;

    cmd_t dec_cmd;
    logic dec_ok;
    logic push, pop;

    always_comb begin
        dec_ok        = 1'b1;
        dec_cmd.kind  = CMD_APPEND;
        dec_cmd.pos   = s_data.position_in;
        dec_cmd.value = s_data.value_in;
        unique case (s_data.op)
            OP_APPEND: dec_cmd.kind = CMD_APPEND;
            OP_FRONT:  dec_cmd.kind = CMD_FRONT;
            OP_INSERT: dec_cmd.kind = CMD_INSERT;
            OP_DELETE: dec_cmd.kind = CMD_DELETE;
            OP_DUMP:   dec_cmd.kind = CMD_DUMP;
            default:   dec_ok = 1'b0;
        endcase
    end

    assign s_ready   = (fill_reg != QCW'(QDEPTH));
    assign push      = s_valid && s_ready && dec_ok;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_valid = (fill_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + QCW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= dec_cmd;
        end
    end

    assign cmd = q_mem[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: src/ils_back.sv
// ----------------------------------------------------------------------------
// ils_back
// Executes queued commands on a row of shifting cells and drives the result
// register. Insert and delete each complete in one row update; dump rotates
// the row once per element so the front cell always holds the element to send.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_back
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire cmd_t                        cmd,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output ils_out_t                         m_data,
    output logic [$clog2(DEPTH + 1)-1:0]     count
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    logic signed [31:0] ent_reg  [DEPTH];
    logic signed [31:0] ent_next [DEPTH];

    back_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] dump_reg, dump_next;
    ils_out_t      out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    cell_op_t        cell_op;
    logic [CMPW-1:0] tgt;
    logic [CMPW-1:0] cnt_x;
    logic            out_free;
    logic            is_full;
    logic            dump_last;

    assign cnt_x     = CMPW'(count_reg);
    assign out_free  = !out_valid_reg || m_ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign dump_last = (CW'(dump_reg + CW'(1)) == count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            dump_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_reg      <= dump_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_next      = dump_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cell_op        = CELL_HOLD;
        tgt            = '0;
        cmd_ready      = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                cmd_ready = out_free;
                if (cmd_valid && out_free) begin
                    out_valid_next            = 1'b1;
                    out_next.status           = ST_DONE;
                    out_next.element          = '0;
                    out_next.element_position = '0;
                    out_next.last             = 1'b1;
                    unique case (cmd.kind)
                        CMD_APPEND, CMD_FRONT: begin
                            if (is_full) begin
                                out_next.status = ST_FULL;
                            end else begin
                                cell_op    = CELL_INSERT;
                                tgt        = (cmd.kind == CMD_APPEND) ? cnt_x : '0;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_INSERT: begin
                            if (CMPW'(cmd.pos) > cnt_x) begin
                                out_next.status = ST_RANGE;
                            end else if (is_full) begin
                                out_next.status = ST_FULL;
                            end else begin
                                cell_op    = CELL_INSERT;
                                tgt        = CMPW'(cmd.pos);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (CMPW'(cmd.pos) >= cnt_x) begin
                                out_next.status = ST_RANGE;
                            end else begin
                                cell_op    = CELL_DELETE;
                                tgt        = CMPW'(cmd.pos);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (count_reg == '0) begin
                                out_next.status = ST_EMPTY;
                            end else begin
                                out_next.status  = ST_ELEMENT;
                                out_next.element = ent_reg[0];
                                out_next.last    = (count_reg == CW'(1));
                                cell_op          = CELL_ROTATE;
                                if (count_reg != CW'(1)) begin
                                    state_next = BK_DUMP;
                                    dump_next  = CW'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                    out_next.count_out = 5'(count_next);
                end
            end
            BK_DUMP: begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_next.status           = ST_ELEMENT;
                    out_next.element          = ent_reg[0];
                    out_next.element_position = 4'(dump_reg);
                    out_next.last             = dump_last;
                    out_next.count_out        = 5'(count_reg);
                    cell_op                   = CELL_ROTATE;
                    dump_next                 = CW'(dump_reg + CW'(1));
                    if (dump_last) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    // one cell per list position; each looks only at its neighbors and cell 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] prev_val;
        logic signed [31:0] succ_val;
        logic [CMPW-1:0]    gi;
        logic [CMPW-1:0]    gi1;

        if (g > 0) begin : g_prev
            assign prev_val = ent_reg[g-1];
        end else begin : g_noprev
            assign prev_val = ent_reg[g];
        end
        if (g < DEPTH - 1) begin : g_succ
            assign succ_val = ent_reg[g+1];
        end else begin : g_nosucc
            assign succ_val = ent_reg[g];
        end

        assign gi  = CMPW'(g);
        assign gi1 = CMPW'(g + 1);

        always_comb begin
            ent_next[g] = ent_reg[g];
            unique case (cell_op)
                CELL_HOLD: ;
                CELL_INSERT: begin
                    if (gi == tgt) begin
                        ent_next[g] = cmd.value;
                    end else if (gi > tgt && gi <= cnt_x) begin
                        ent_next[g] = prev_val;
                    end
                end
                CELL_DELETE: begin
                    if (gi >= tgt && gi1 < cnt_x) begin
                        ent_next[g] = succ_val;
                    end
                end
                CELL_ROTATE: begin
                    // front element wraps to the back of the occupied range
                    if (gi1 < cnt_x) begin
                        ent_next[g] = succ_val;
                    end else if (gi1 == cnt_x) begin
                        ent_next[g] = ent_reg[0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign count   = count_reg;

endmodule

`default_nettype wire

FILE: src/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list of signed 32-bit values with append, insert at front,
// insert at index, delete at index and dump.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one operation per transaction. m_valid/
//   m_ready/m_data return results: one status result per operation, or one
//   element result per stored value for a dump (last set on the final one,
//   a single empty-status result for an empty list). Unused op codes are
//   accepted and produce nothing.
//   Each operation passes through the command queue and is then executed
//   from the queue head into the result register when the back end is free.
//   In the back end, insert and delete each complete in one update of the
//   shifting cell row; a dump rotates the row once per element sent and
//   takes no new command until it is done. A 2-entry command queue takes up
//   to two further operations while the back end works or waits.
//   Reset clears the list to empty and drops queued commands and results.
//   When m_ready is low the back end holds; the queue fills and s_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ils_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ils_out_t      m_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic          cmd_valid;
    logic          cmd_ready;
    cmd_t          cmd;
    logic [CW-1:0] list_count;

    ils_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ils_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (list_count)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        list_count <= CW'(DEPTH))
        else $error("list count exceeds capacity");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_ELEMENT |-> m_data.last)
        else $error("status result without last marker");

    a_dump_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_ELEMENT && m_data.last |->
            m_data.element_position == 4'(m_data.count_out - 5'd1))
        else $error("last dumped element not at tail position");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(list_count))
        else $error("list changed while result stalled");
`endif

endmodule

`default_nettype wire

FILE: test/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker
// Watches both channels of the indexed list store, keeps its own copy of the
// list, predicts the results of every accepted operation and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module ils_checker
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  ils_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  ils_out_t m_data,
    output int       fail_count,
    output int       pending,
    output int       list_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] list_vals [DEPTH];
    int unsigned        list_len = 0;
    ils_out_t           expected_results [$];
    int                 mismatches = 0;

    function automatic ils_out_t status_result(logic [2:0] st);
        ils_out_t r;
        r = '0;
        r.status    = st;
        r.last      = 1'b1;
        r.count_out = list_len[4:0];
        return r;
    endfunction

    task automatic place_value(int unsigned at, logic signed [31:0] v);
        for (int unsigned i = list_len; i > at; i--) begin
            list_vals[i] = list_vals[i - 1];
        end
        list_vals[at] = v;
        list_len++;
    endtask

    task automatic predict_op(ils_in_t item);
        ils_out_t r;
        case (item.op)
            OP_APPEND, OP_FRONT: begin
                if (list_len >= DEPTH) begin
                    expected_results.push_back(status_result(ST_FULL));
                end else begin
                    place_value((item.op == OP_APPEND) ? list_len : 0, item.value_in);
                    expected_results.push_back(status_result(ST_DONE));
                end
            end
            OP_INSERT: begin
                // index check ranks above the full check
                if (item.position_in > list_len) begin
                    expected_results.push_back(status_result(ST_RANGE));
                end else if (list_len >= DEPTH) begin
                    expected_results.push_back(status_result(ST_FULL));
                end else begin
                    place_value(item.position_in, item.value_in);
                    expected_results.push_back(status_result(ST_DONE));
                end
            end
            OP_DELETE: begin
                if (item.position_in >= list_len) begin
                    expected_results.push_back(status_result(ST_RANGE));
                end else begin
                    for (int unsigned i = item.position_in; i + 1 < list_len; i++) begin
                        list_vals[i] = list_vals[i + 1];
                    end
                    list_len--;
                    expected_results.push_back(status_result(ST_DONE));
                end
            end
            OP_DUMP: begin
                if (list_len == 0) begin
                    expected_results.push_back(status_result(ST_EMPTY));
                end else begin
                    for (int unsigned i = 0; i < list_len; i++) begin
                        r = '0;
                        r.status           = ST_ELEMENT;
                        r.element          = list_vals[i];
                        r.element_position = i[3:0];
                        r.last             = (i + 1 == list_len);
                        r.count_out        = list_len[4:0];
                        expected_results.push_back(r);
                    end
                end
            end
            default: begin
                // unused codes leave the list alone and answer nothing
            end
        endcase
    endtask

    task automatic compare_result(ils_out_t got);
        ils_out_t want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected result status %0d element %0d pos %0d last %0b count %0d",
                         $realtime, got.status, got.element, got.element_position, got.last,
                         got.count_out);
            end
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.element !== want.element ||
            got.element_position !== want.element_position || got.last !== want.last ||
            got.count_out !== want.count_out) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result mismatch", $realtime);
                $display("  expected status %0d element %0d pos %0d last %0b count %0d",
                         want.status, want.element, want.element_position, want.last,
                         want.count_out);
                $display("  actual   status %0d element %0d pos %0d last %0b count %0d",
                         got.status, got.element, got.element_position, got.last,
                         got.count_out);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
            list_len = 0;
        end else begin
            // results lag their operation, so compare before predicting
            if (m_valid && m_ready) begin
                compare_result(m_data);
            end
            if (s_valid && s_ready) begin
                predict_op(s_data);
            end
        end
        fail_count <= mismatches;
        pending    <= expected_results.size();
        list_count <= list_len;
    end

endmodule

FILE: test/tb_indexed_list_store.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_store
// Drives directed and random list operations into the indexed list store
// with random idle cycles on both channels; a checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;
    import ils_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_OPS    = 320;
    localparam int SEGMENT_OPS   = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } mix_mode_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    ils_in_t  s_data  = '0;
    logic     m_ready = 1'b0;
    logic     s_ready;
    logic     m_valid;
    ils_out_t m_data;

    int fail_count;
    int pending;
    int list_count;
    int cycles = 0;
    bit calm   = 1'b0;

    indexed_list_store i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ils_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending),
        .list_count (list_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic send_op(logic [2:0] op, logic [7:0] pos, logic [31:0] val);
        if (!calm) begin
            while ($urandom_range(0, 99) < 10) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid            <= 1'b1;
        s_data.op          <= op;
        s_data.position_in <= pos;
        s_data.value_in    <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the sender until every predicted result has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 32'h8000_0000;
        if (r < 16) return 32'h7fff_ffff;
        if (r < 20) return 32'h0000_0000;
        if (r < 24) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // mostly legal positions, with edges, one past the end and wild values
    function automatic logic [7:0] pick_position(logic [2:0] op, int n);
        int r;
        int top_legal;
        r = $urandom_range(0, 99);
        top_legal = (op == OP_DELETE) ? ((n > 0) ? n - 1 : 0) : n;
        if (r < 70) return 8'($urandom_range(0, top_legal));
        if (r < 80) return 8'(n);
        if (r < 88) return 8'(n + 1);
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] pick_op(mix_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                if (r < 25) return OP_APPEND;
                if (r < 45) return OP_FRONT;
                if (r < 75) return OP_INSERT;
                if (r < 85) return OP_DELETE;
                if (r < 95) return OP_DUMP;
            end
            MODE_SHRINK: begin
                if (r < 8) return OP_APPEND;
                if (r < 15) return OP_FRONT;
                if (r < 25) return OP_INSERT;
                if (r < 85) return OP_DELETE;
                if (r < 97) return OP_DUMP;
            end
            default: begin
                if (r < 18) return OP_APPEND;
                if (r < 33) return OP_FRONT;
                if (r < 53) return OP_INSERT;
                if (r < 78) return OP_DELETE;
                if (r < 95) return OP_DUMP;
            end
        endcase
        return 3'($urandom_range(OP_DUMP + 1, 7));
    endfunction

    initial begin
        int        done_ops;
        logic [2:0] op;
        mix_mode_t mode;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list corner cases
        send_op(OP_DUMP, 8'd0, 32'd0);
        send_op(OP_DELETE, 8'd0, 32'd0);
        send_op(OP_INSERT, 8'd1, 32'd5);
        // inserts at every kind of spot, value extremes
        send_op(OP_INSERT, 8'd0, 32'h8000_0000);
        send_op(OP_APPEND, 8'd0, 32'h7fff_ffff);
        send_op(OP_FRONT, 8'hff, 32'hffff_ffff);
        send_op(OP_INSERT, 8'd3, 32'd0);
        send_op(OP_INSERT, 8'd2, 32'h5a5a_a5a5);
        send_op(OP_INSERT, 8'd6, 32'd1);
        send_op(OP_DUMP, 8'd0, 32'd0);
        // deletes at head, in the middle and out of range
        send_op(OP_DELETE, 8'd0, 32'd0);
        send_op(OP_DELETE, 8'd2, 32'd0);
        send_op(OP_DELETE, 8'd3, 32'd0);
        send_op(OP_DELETE, 8'hff, 32'hffff_ffff);
        for (int code = OP_DUMP + 1; code < 8; code++) begin
            send_op(3'(code), 8'hff, 32'hffff_ffff);
        end
        send_op(OP_APPEND, 8'h00, 32'h0000_0001);
        send_op(OP_DUMP, 8'd0, 32'd0);

        done_ops = 0;
        while (done_ops < RANDOM_OPS) begin
            mode = mix_mode_t'((done_ops / SEGMENT_OPS) % 3);
            if (done_ops == 4 * SEGMENT_OPS) begin
                calm <= 1'b1;
            end else if (done_ops == 5 * SEGMENT_OPS) begin
                calm <= 1'b0;
            end
            if (done_ops == 6 * SEGMENT_OPS) begin
                wait_drained();
            end
            op = pick_op(mode);
            send_op(op, pick_position(op, list_count), pick_value());
            if (op <= OP_DUMP) begin
                done_ops++;
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
